// ----- rtl/core/sdjq_pkg.sv -----
package sdjq_pkg;

   // field widths of one job
   localparam int SPRITE_W = 10;
   localparam int FRAME_W  = 9;
   localparam int LAYER_W  = 8;
   localparam int POS_W    = 16;
   localparam int MODE_W   = 8;
   localparam int SLOT_W   = 7;
   localparam int CFG_W    = 11;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // request kinds
   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SPR  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd3;

   // one queue entry, sprite in the lowest bits
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [POS_W-1:0]    y;
      logic [POS_W-1:0]    x;
      logic [LAYER_W-1:0]  layer;
      logic [FRAME_W-1:0]  frame;
      logic [SPRITE_W-1:0] sprite;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ----- rtl/core/sdjq_cell.sv -----
module sdjq_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  sdjq_pkg::entry_type d_in,
   output sdjq_pkg::entry_type q_out
);

   sdjq_pkg::entry_type entry_ff;
   sdjq_pkg::entry_type entry_in;

   // take the neighbour's entry on every rotation step
   assign entry_in = shift_en ? d_in : entry_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q_out = entry_ff;

endmodule

// ----- rtl/core/sdjq_ctrl.sv -----
module sdjq_ctrl #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // request side
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sdjq_pkg::ACTION_W-1:0]       req_action,
   input  sdjq_pkg::entry_type                 req_job,
   input  logic [sdjq_pkg::SLOT_W-1:0]         req_position,
   input  logic [sdjq_pkg::CFG_W-1:0]          sprite_count,
   // ring of cells
   output logic                                shift_en,
   input  sdjq_pkg::entry_type                 head,
   output sdjq_pkg::entry_type                 tail,
   // result side
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sdjq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sdjq_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [sdjq_pkg::SLOT_W-1:0]         rsp_count,
   output sdjq_pkg::entry_type                 rsp_entry
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int PW = (CW > sdjq_pkg::SLOT_W) ? CW : sdjq_pkg::SLOT_W;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SWEEP = 3'b010,
      S_DONE  = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    cnt_ff, cnt_in;
   logic [IW-1:0]                    t_ff, t_in;
   logic                             found_ff, found_in;
   logic                             place_ok_ff, place_ok_in;
   logic [sdjq_pkg::ACTION_W-1:0]    op_ff, op_in;
   sdjq_pkg::entry_type              job_ff, job_in;
   sdjq_pkg::entry_type              hold_ff, hold_in;
   sdjq_pkg::entry_type              rd_ff, rd_in;
   logic [sdjq_pkg::SLOT_W-1:0]      pos_ff, pos_in;
   logic [CW-1:0]                    slot_ff, slot_in;
   logic [sdjq_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sdjq_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [sdjq_pkg::SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [sdjq_pkg::SLOT_W-1:0]      rsp_count_ff, rsp_count_in;
   sdjq_pkg::entry_type              rsp_entry_ff, rsp_entry_in;

   logic          accept;
   logic          last_step;
   logic          job_less;
   logic          place_now;
   logic          rsp_free;
   logic [PW-1:0] t_ext, cnt_ext, pos_ext, req_pos_ext;
   logic [sdjq_pkg::STATUS_W-1:0] new_status;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (t_ff == IW'(QUEUE_DEPTH - 1));

   assign t_ext       = PW'(t_ff);
   assign cnt_ext     = PW'(cnt_ff);
   assign pos_ext     = PW'(pos_ff);
   assign req_pos_ext = PW'(req_position);

   // job sorts before the entry at the head: lower layer, or same layer and lower y
   assign job_less = (job_ff.layer < head.layer) ||
                     ((job_ff.layer == head.layer) && ($signed(job_ff.y) < $signed(head.y)));

   // the step at which the job goes in
   always_comb begin
      if (op_ff == sdjq_pkg::ACT_ADD) begin
         place_now = !found_ff && ((t_ext == cnt_ext) || ((t_ext < cnt_ext) && job_less));
      end else begin
         place_now = !found_ff && (t_ext == pos_ext) && (op_ff == sdjq_pkg::ACT_INSERT);
      end
   end

   // status of a new request, first failing check wins
   always_comb begin
      new_status = sdjq_pkg::ST_OK;
      case (req_action)
         sdjq_pkg::ACT_ADD, sdjq_pkg::ACT_INSERT: begin
            if ({1'b0, req_job.sprite} >= sprite_count) begin
               new_status = sdjq_pkg::ST_BAD_SPR;
            end else if (cnt_ext >= PW'(QUEUE_DEPTH)) begin
               new_status = sdjq_pkg::ST_FULL;
            end else if ((req_action == sdjq_pkg::ACT_INSERT) && (req_pos_ext > cnt_ext)) begin
               new_status = sdjq_pkg::ST_BAD_POS;
            end
         end
         sdjq_pkg::ACT_READ: begin
            if (req_pos_ext >= cnt_ext) begin
               new_status = sdjq_pkg::ST_BAD_POS;
            end
         end
         default: begin
            new_status = sdjq_pkg::ST_OK;
         end
      endcase
   end

   // sequencer: one full rotation of the ring per add, insert or read
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      t_in          = t_ff;
      found_in      = found_ff;
      place_ok_in   = place_ok_ff;
      op_in         = op_ff;
      job_in        = job_ff;
      hold_in       = hold_ff;
      rd_in         = rd_ff;
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_entry_in  = rsp_entry_ff;
      shift_en      = 1'b0;
      tail          = head;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_action;
               job_in      = req_job;
               pos_in      = req_position;
               t_in        = '0;
               found_in    = 1'b0;
               rd_in       = '0;
               status_in   = new_status;
               place_ok_in = (new_status == sdjq_pkg::ST_OK) &&
                             ((req_action == sdjq_pkg::ACT_ADD) ||
                              (req_action == sdjq_pkg::ACT_INSERT));
               if (req_action == sdjq_pkg::ACT_CLEAR) begin
                  cnt_in   = '0;
                  slot_in  = '0;
                  state_in = S_DONE;
               end else begin
                  slot_in  = (req_action == sdjq_pkg::ACT_ADD) ? cnt_ff : CW'(req_position);
                  state_in = S_SWEEP;
               end
            end
         end
         S_SWEEP: begin
            shift_en = 1'b1;
            t_in     = t_ff + 1'b1;
            if (place_now) begin
               found_in = 1'b1;
               if (op_ff == sdjq_pkg::ACT_ADD) begin
                  slot_in = CW'(t_ff);
               end
            end
            // splice the job in and delay the rest by one place
            if (place_ok_ff && place_now) begin
               tail    = job_ff;
               hold_in = head;
            end else if (place_ok_ff && found_ff) begin
               tail    = hold_ff;
               hold_in = head;
            end
            // pick up the entry a read asks for
            if ((op_ff == sdjq_pkg::ACT_READ) && (status_ff == sdjq_pkg::ST_OK) &&
                (t_ext == pos_ext)) begin
               rd_in = head;
            end
            if (last_step) begin
               t_in     = '0;
               state_in = S_DONE;
               if (place_ok_ff) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = sdjq_pkg::SLOT_W'(slot_ff);
               rsp_count_in  = sdjq_pkg::SLOT_W'(cnt_ff);
               rsp_entry_in  = rd_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         t_ff         <= '0;
         found_ff     <= 1'b0;
         place_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         t_ff         <= t_in;
         found_ff     <= found_in;
         place_ok_ff  <= place_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      job_ff        <= job_in;
      hold_ff       <= hold_in;
      rd_ff         <= rd_in;
      pos_ff        <= pos_in;
      slot_ff       <= slot_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_entry  = rsp_entry_ff;

endmodule

// ----- rtl/core/sorted_draw_job_queue_top.sv -----
// Sorted draw job queue.
// Request channel (req_): one request per handshake; req_tuser carries the action
// (add sorted, insert at position, read entry, clear) and req_tdata the job and position.
// Result channel (rsp_): exactly one result per request, in request order; rsp_tuser is
// the status, rsp_tdata the slot, the count after the request and the entry read.
// Configuration (csr_): writes the sprite count; always ready, write only while idle.
// Jobs live in a ring of QUEUE_DEPTH cells. Add, insert and read rotate the ring once,
// one cell per cycle, comparing or splicing at the head; clear does not rotate. One
// request is worked at a time: the next is taken once the result is in the output register.
// A new request is taken while the previous result still waits in the output register.
// Reset empties the queue and zeroes the sprite count; cell contents are left as they are.
// If the receiver stalls, the result is held and the next finished result waits in the
// sequencer, which stops taking requests until the output register frees up.
module sorted_draw_job_queue_top #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   // sprite_number, frame_number, layer, pos_x, pos_y, draw_mode, position, zero fill
   input  logic [79:0] req_tdata,
   // action
   input  logic [1:0]  req_tuser,
   // result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot, count, out_sprite, out_frame, out_layer, out_x, out_y, out_mode, zero fill
   output logic [87:0] rsp_tdata,
   // status
   output logic [1:0]  rsp_tuser,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);

   localparam int EW = sdjq_pkg::ENTRY_W;

   logic [sdjq_pkg::CFG_W-1:0] sprite_count_ff;
   logic [sdjq_pkg::CFG_W-1:0] sprite_count_in;

   sdjq_pkg::entry_type req_job;
   sdjq_pkg::entry_type rsp_entry;
   sdjq_pkg::entry_type head;
   sdjq_pkg::entry_type tail;
   sdjq_pkg::entry_type ring [QUEUE_DEPTH];
   logic                shift_en;
   logic [sdjq_pkg::SLOT_W-1:0] rsp_slot;
   logic [sdjq_pkg::SLOT_W-1:0] rsp_count;

   // sprite count register
   assign csr_ready       = 1'b1;
   assign sprite_count_in = (csr_valid && csr_ready) ? csr_data : sprite_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_count_ff <= '0;
      end else begin
         sprite_count_ff <= sprite_count_in;
      end
   end

   assign req_job = sdjq_pkg::entry_type'(req_tdata[EW-1:0]);

   sdjq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_action   (req_tuser),
      .req_job      (req_job),
      .req_position (req_tdata[EW+sdjq_pkg::SLOT_W-1:EW]),
      .sprite_count (sprite_count_ff),
      .shift_en     (shift_en),
      .head         (head),
      .tail         (tail),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_status   (rsp_tuser),
      .rsp_slot     (rsp_slot),
      .rsp_count    (rsp_count),
      .rsp_entry    (rsp_entry)
   );

   // ring of cells: each hands its entry down towards the head, tail fed by the sequencer
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == QUEUE_DEPTH - 1) begin : g_last
         sdjq_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d_in     (tail),
            .q_out    (ring[i])
         );
      end else begin : g_mid
         sdjq_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d_in     (ring[i+1]),
            .q_out    (ring[i])
         );
      end
   end

   assign head = ring[0];

   assign rsp_tdata = {7'd0, rsp_entry, rsp_count, rsp_slot};

endmodule
